FILE: hdl/hcd_pkg.sv
`default_nettype none

package hcd_pkg;

    localparam int MAX_CODE_LEN = 8;
    localparam int NUM_SYMBOLS  = 256;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LEFTOVER = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/hcd_byte_if.sv
`default_nettype none

interface hcd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [hcd_pkg::BYTE_W-1:0]    in_byte;
    logic                          stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/hcd_result_if.sv
`default_nettype none

interface hcd_result_if;
    logic                          valid;
    logic                          ready;
    logic [hcd_pkg::BYTE_W-1:0]    symbol;
    logic [hcd_pkg::STATUS_W-1:0]  status;
    logic                          last_of_run;
    logic                          stream_done;

    modport source (output valid, output symbol, output status, output last_of_run,
                    output stream_done, input ready);
    modport sink   (input valid, input symbol, input status, input last_of_run,
                    input stream_done, output ready);
endinterface

`default_nettype wire

FILE: hdl/huffman_container_decoder.sv
// Huffman container decoder.
// container (sink): one byte of the container per transfer; stream_end flags
//   the final byte. Count byte, (length, symbol, code) triples, padding byte,
//   then data bytes whose bits are consumed LSB first.
// result (source): decoded symbols with a status, last_of_run on the last
//   result caused by one input byte, stream_done on the final one.
// Header bytes are taken in S_IDLE. A data byte walks its valid bits through
//   the code store's read port: each bit takes an address step (S_BIT), then
//   a compare of the registered read data (S_CHK), and the byte closes with
//   S_LEFT and S_FLUSH; container.ready stays low from the transfer until the
//   byte is done. Results pass through a holding stage and an output register.
//   The walk blocks only when both stages are full and the receiver does not
//   take the output.
// After reset and after every stream_end byte the code store is swept clear,
//   one entry a cycle over all 2^(MAX_CODE_LEN+1) entries (512 by default); the
//   container channel is not ready during the sweep.
// When the receiver stalls, the result is held; once the holding stage is also
//   full, the walk waits at the next bit that produces a result.
`default_nettype none

module huffman_container_decoder #(
    parameter int MAX_CODE_LEN = hcd_pkg::MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcd_pkg::NUM_SYMBOLS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hcd_byte_if.sink        container,
    hcd_result_if.source    result
);

    localparam int IDX_W = MAX_CODE_LEN + 1;
    localparam int DEPTH = 1 << IDX_W;
    localparam int LEN_W = 4;
    localparam int SYM_W = hcd_pkg::BYTE_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_LEFT  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_TABLE = 2'd1;
    localparam logic [1:0] PH_PAD   = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    localparam logic [LEN_W-1:0] FULL_BITS = LEN_W'(8);

    logic [SYM_W:0] mem [DEPTH];

    logic [2:0]              state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic [7:0]              entries_reg, entries_next;
    logic [1:0]              tpos_reg, tpos_next;
    logic [LEN_W-1:0]        plen_reg, plen_next;
    logic [SYM_W-1:0]        psym_reg, psym_next;
    logic [LEN_W-1:0]        lvb_reg, lvb_next;
    logic [MAX_CODE_LEN-1:0] code_reg, code_next;
    logic [LEN_W-1:0]        clen_reg, clen_next;
    logic [7:0]              byte_reg, byte_next;
    logic                    end_reg, end_next;
    logic [2:0]              bcnt_reg, bcnt_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;

    logic                         pend_vld_reg, pend_vld_next;
    logic [SYM_W-1:0]             pend_sym_reg, pend_sym_next;
    logic [hcd_pkg::STATUS_W-1:0] pend_st_reg, pend_st_next;

    logic                         out_vld_reg;
    logic [SYM_W-1:0]             out_sym_reg;
    logic [hcd_pkg::STATUS_W-1:0] out_st_reg;
    logic                         out_last_reg;
    logic                         out_done_reg;

    logic [SYM_W:0]               rd_reg;

    logic                    we;
    logic [IDX_W-1:0]        wa;
    logic [SYM_W:0]          wd;
    logic                    re;
    logic [IDX_W-1:0]        ra;
    logic                    push;
    logic                    push_last;
    logic                    push_done;
    logic                    out_free;
    logic                    bit_in;
    logic [MAX_CODE_LEN-1:0] code_ins;
    logic [LEN_W-1:0]        len_inc;
    logic [LEN_W-1:0]        nbits;
    logic                    last_bit;
    logic                    do_clear;
    logic                    advance;
    logic [7:0]              ent_dec;
    logic                    hit;

    function automatic logic [IDX_W-1:0] store_idx(input logic [LEN_W-1:0] len,
                                                    input logic [MAX_CODE_LEN-1:0] code);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < MAX_CODE_LEN; j++)
        begin
            idx[j] = (LEN_W'(j) < len) ? code[j] : (LEN_W'(j) == len);
        end
        idx[MAX_CODE_LEN] = (len == LEN_W'(MAX_CODE_LEN));
        return idx;
    endfunction

    assign out_free = !out_vld_reg || result.ready;
    assign bit_in   = byte_reg[bcnt_reg];
    assign len_inc  = clen_reg + LEN_W'(1);
    assign nbits    = end_reg ? lvb_reg : FULL_BITS;
    assign last_bit = ((LEN_W'(bcnt_reg) + LEN_W'(1)) == nbits);
    assign hit      = rd_reg[SYM_W];
    assign ent_dec  = (entries_reg != 8'd0) ? entries_reg - 8'd1 : entries_reg;

    always_comb
    begin
        code_ins = code_reg;
        for (int j = 0; j < MAX_CODE_LEN; j++)
        begin
            if (LEN_W'(j) == clen_reg)
            begin
                code_ins[j] = code_reg[j] | bit_in;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        entries_next  = entries_reg;
        tpos_next     = tpos_reg;
        plen_next     = plen_reg;
        psym_next     = psym_reg;
        lvb_next      = lvb_reg;
        code_next     = code_reg;
        clen_next     = clen_reg;
        byte_next     = byte_reg;
        end_next      = end_reg;
        bcnt_next     = bcnt_reg;
        clr_next      = clr_reg;
        pend_vld_next = pend_vld_reg;
        pend_sym_next = pend_sym_reg;
        pend_st_next  = pend_st_reg;
        we            = 1'b0;
        wa            = store_idx(plen_reg, container.in_byte[MAX_CODE_LEN-1:0]);
        wd            = {1'b1, psym_reg};
        re            = 1'b0;
        ra            = store_idx(len_inc, code_ins);
        push          = 1'b0;
        push_last     = 1'b0;
        push_done     = 1'b0;
        do_clear      = 1'b0;
        advance       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (container.valid)
                begin
                    byte_next = container.in_byte;
                    end_next  = container.stream_end;
                    bcnt_next = '0;
                    case (phase_reg)
                        PH_COUNT:
                        begin
                            entries_next = container.in_byte;
                            tpos_next    = 2'd0;
                            phase_next   = (container.in_byte == 8'd0) ? PH_PAD : PH_TABLE;
                        end
                        PH_TABLE:
                        begin
                            if (tpos_reg == 2'd0)
                            begin
                                plen_next = (container.in_byte > 8'd15) ? '0
                                            : container.in_byte[LEN_W-1:0];
                                tpos_next = 2'd1;
                            end
                            else if (tpos_reg == 2'd1)
                            begin
                                psym_next = container.in_byte;
                                tpos_next = 2'd2;
                            end
                            else
                            begin
                                if (plen_reg != '0 && plen_reg <= LEN_W'(MAX_CODE_LEN)
                                    && {1'b0, psym_reg} < (SYM_W+1)'(NUM_SYMBOLS))
                                begin
                                    we = 1'b1;
                                end
                                tpos_next    = 2'd0;
                                entries_next = ent_dec;
                                if (ent_dec == 8'd0)
                                begin
                                    phase_next = PH_PAD;
                                end
                            end
                        end
                        PH_PAD:
                        begin
                            lvb_next   = (container.in_byte >= 8'd1 && container.in_byte <= 8'd7)
                                         ? LEN_W'(8'd8 - container.in_byte) : FULL_BITS;
                            phase_next = PH_DATA;
                        end
                        default:
                        begin
                            state_next = S_BIT;
                        end
                    endcase
                    if (container.stream_end && phase_reg != PH_DATA)
                    begin
                        do_clear = 1'b1;
                    end
                end
            end
            S_BIT:
            begin
                code_next  = code_ins;
                clen_next  = len_inc;
                re         = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (hit || clen_reg == LEN_W'(MAX_CODE_LEN))
                begin
                    // a new result displaces the held one into the output register
                    if (!pend_vld_reg || out_free)
                    begin
                        push          = pend_vld_reg;
                        pend_vld_next = 1'b1;
                        pend_sym_next = hit ? rd_reg[SYM_W-1:0] : '0;
                        pend_st_next  = hit ? hcd_pkg::ST_OK : hcd_pkg::ST_NO_MATCH;
                        code_next     = '0;
                        clen_next     = '0;
                        advance       = 1'b1;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (last_bit)
                    begin
                        state_next = S_LEFT;
                    end
                    else
                    begin
                        bcnt_next  = bcnt_reg + 3'd1;
                        state_next = S_BIT;
                    end
                end
            end
            S_LEFT:
            begin
                if (end_reg && clen_reg != '0)
                begin
                    if (!pend_vld_reg || out_free)
                    begin
                        push          = pend_vld_reg;
                        pend_vld_next = 1'b1;
                        pend_sym_next = '0;
                        pend_st_next  = hcd_pkg::ST_LEFTOVER;
                        state_next    = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    push          = pend_vld_reg;
                    push_last     = 1'b1;
                    push_done     = end_reg;
                    pend_vld_next = 1'b0;
                    if (end_reg)
                    begin
                        do_clear = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_clear)
        begin
            state_next   = S_CLEAR;
            clr_next     = '0;
            phase_next   = PH_COUNT;
            entries_next = '0;
            tpos_next    = '0;
            plen_next    = '0;
            psym_next    = '0;
            lvb_next     = FULL_BITS;
            code_next    = '0;
            clen_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            phase_reg    <= PH_COUNT;
            entries_reg  <= '0;
            tpos_reg     <= '0;
            plen_reg     <= '0;
            psym_reg     <= '0;
            lvb_reg      <= FULL_BITS;
            code_reg     <= '0;
            clen_reg     <= '0;
            end_reg      <= 1'b0;
            bcnt_reg     <= '0;
            clr_reg      <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            entries_reg  <= entries_next;
            tpos_reg     <= tpos_next;
            plen_reg     <= plen_next;
            psym_reg     <= psym_next;
            lvb_reg      <= lvb_next;
            code_reg     <= code_next;
            clen_reg     <= clen_next;
            end_reg      <= end_next;
            bcnt_reg     <= bcnt_next;
            clr_reg      <= clr_next;
            pend_vld_reg <= pend_vld_next;
            if (push)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        pend_sym_reg <= pend_sym_next;
        pend_st_reg  <= pend_st_next;
        if (push)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= push_last;
            out_done_reg <= push_done;
        end
    end

    assign container.ready    = (state_reg == S_IDLE);
    assign result.valid       = out_vld_reg;
    assign result.symbol      = out_sym_reg;
    assign result.status      = out_st_reg;
    assign result.last_of_run = out_last_reg;
    assign result.stream_done = out_done_reg;

endmodule

`default_nettype wire

FILE: hdl/hcd_checker.sv
`default_nettype none

module hcd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic [hcd_pkg::BYTE_W-1:0]   res_symbol,
    input wire logic [hcd_pkg::STATUS_W-1:0] res_status,
    input wire logic                         res_last,
    input wire logic                         res_done
);

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != hcd_pkg::ST_OK |-> res_symbol == '0)
        else $error("error result carries a symbol");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_status == hcd_pkg::ST_OK || res_status == hcd_pkg::ST_NO_MATCH
                       || res_status == hcd_pkg::ST_LEFTOVER))
        else $error("undefined status code");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> res_last)
        else $error("stream end without end of run");

endmodule

bind huffman_container_decoder hcd_checker u_hcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_symbol (result.symbol),
    .res_status (result.status),
    .res_last   (result.last_of_run),
    .res_done   (result.stream_done)
);

`default_nettype wire
